@@ design/utf8v_pkg.sv @@
`timescale 1ns / 1ps

package utf8v_pkg;

  // One byte of the payload being checked.
  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } utf8v_in_t;

  // Verdict given on the last byte of a payload.
  typedef struct packed {
    logic utf8_valid;
    logic control_free;
  } utf8v_out_t;

  localparam int unsigned CpWidth = 21;

  // Decoder state carried from byte to byte.
  typedef struct packed {
    logic [1:0]         bytes_pending;
    logic [1:0]         sequence_length;
    logic [CpWidth-1:0] code_accumulator;
    logic               utf8_error_seen;
    logic               control_error_seen;
  } utf8v_state_t;

  // Lead and continuation byte patterns.
  localparam logic [7:0] LeadMask2 = 8'hE0;
  localparam logic [7:0] LeadTag2  = 8'hC0;
  localparam logic [7:0] LeadMask3 = 8'hF0;
  localparam logic [7:0] LeadTag3  = 8'hE0;
  localparam logic [7:0] LeadMask4 = 8'hF8;
  localparam logic [7:0] LeadTag4  = 8'hF0;
  localparam logic [7:0] ContMask  = 8'hC0;
  localparam logic [7:0] ContTag   = 8'h80;
  localparam logic [7:0] CtrlLimit = 8'h20;

  localparam logic [7:0] ChTab = 8'h09;
  localparam logic [7:0] ChLf  = 8'h0A;
  localparam logic [7:0] ChFf  = 8'h0C;
  localparam logic [7:0] ChCr  = 8'h0D;

  // Codepoint bounds.
  localparam logic [CpWidth-1:0] MinCp2       = 21'h00080;
  localparam logic [CpWidth-1:0] MinCp3       = 21'h00800;
  localparam logic [CpWidth-1:0] MinCp4       = 21'h10000;
  localparam logic [CpWidth-1:0] MaxCp        = 21'h10FFFF;
  localparam logic [CpWidth-1:0] SurrogateLo  = 21'h0D800;
  localparam logic [CpWidth-1:0] SurrogateHi  = 21'h0DFFF;

  // Sequence length codes (continuation bytes after the lead).
  localparam logic [1:0] SeqOne   = 2'd1;
  localparam logic [1:0] SeqTwo   = 2'd2;
  localparam logic [1:0] SeqThree = 2'd3;

endpackage

@@ design/utf8v_step.sv @@
`timescale 1ns / 1ps

// Per-byte decoder update: next state and the verdict for a last byte.
module utf8v_step import utf8v_pkg::*; (
  input  utf8v_state_t st,
  input  utf8v_in_t    item,
  output utf8v_state_t st_next,
  output utf8v_out_t   verdict
);

  logic [7:0]         b;
  logic               forbidden;
  logic               overlong;
  logic               out_of_range;
  logic [CpWidth-1:0] acc_shift;
  utf8v_state_t       upd;

  assign b = item.data_byte;
  assign forbidden = (b < CtrlLimit) &&
                     !(b == ChTab || b == ChLf || b == ChCr || b == ChFf);
  assign acc_shift = {st.code_accumulator[CpWidth-7:0], b[5:0]};

  always_comb begin
    overlong = ((st.sequence_length == SeqOne)   && (acc_shift < MinCp2)) ||
               ((st.sequence_length == SeqTwo)   && (acc_shift < MinCp3)) ||
               ((st.sequence_length == SeqThree) && (acc_shift < MinCp4));
    out_of_range = (acc_shift > MaxCp) ||
                   ((acc_shift >= SurrogateLo) && (acc_shift <= SurrogateHi));
  end

  always_comb begin
    upd = st;
    if (forbidden) begin
      upd.control_error_seen = 1'b1;
      upd.utf8_error_seen    = 1'b1;
    end
    if (st.bytes_pending == 2'd0) begin
      if (!b[7]) begin
        // plain ASCII
      end else if ((b & LeadMask2) == LeadTag2) begin
        upd.bytes_pending    = SeqOne;
        upd.sequence_length  = SeqOne;
        upd.code_accumulator = {{(CpWidth-5){1'b0}}, b[4:0]};
      end else if ((b & LeadMask3) == LeadTag3) begin
        upd.bytes_pending    = SeqTwo;
        upd.sequence_length  = SeqTwo;
        upd.code_accumulator = {{(CpWidth-4){1'b0}}, b[3:0]};
      end else if ((b & LeadMask4) == LeadTag4) begin
        upd.bytes_pending    = SeqThree;
        upd.sequence_length  = SeqThree;
        upd.code_accumulator = {{(CpWidth-3){1'b0}}, b[2:0]};
      end else begin
        upd.utf8_error_seen = 1'b1;
      end
    end else if ((b & ContMask) != ContTag) begin
      // broken sequence: drop it, next byte is read as a lead
      upd.utf8_error_seen  = 1'b1;
      upd.bytes_pending    = 2'd0;
      upd.sequence_length  = 2'd0;
      upd.code_accumulator = '0;
    end else begin
      upd.code_accumulator = acc_shift;
      upd.bytes_pending    = st.bytes_pending - 2'd1;
      if (st.bytes_pending == 2'd1 && (overlong || out_of_range)) begin
        upd.utf8_error_seen = 1'b1;
      end
    end
  end

  always_comb begin
    verdict.utf8_valid   = !(upd.utf8_error_seen || (upd.bytes_pending != 2'd0));
    verdict.control_free = !upd.control_error_seen;
    st_next = item.last_byte ? '0 : upd;
  end

endmodule

@@ design/utf8_text_validator_core.sv @@
`timescale 1ns / 1ps
// A byte accepted into the input register updates the decoder state as it
// advances; a last byte also loads the result register and sets verdict_valid.
// Throughput: one byte per clock barring stalls, set by the single decode stage.
// A held verdict stalls the input only when the staged byte is also a last byte.
// Reset (rst, synchronous, active high) clears decoder state and both valids.

module utf8_text_validator_core import utf8v_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       byte_valid,
  output logic       byte_stall,
  input  utf8v_in_t  byte_item,
  output logic       verdict_valid,
  input  logic       verdict_stall,
  output utf8v_out_t verdict_item
);

  // Input register: one byte waiting for the decoder.
  logic         s1_valid;
  utf8v_in_t    s1_item;

  // Decoder state between bytes.
  utf8v_state_t st;
  utf8v_state_t st_next;
  utf8v_out_t   verdict_next;

  logic accept;
  logic slot_free;
  logic advance;

  utf8v_step u_step (
    .st      (st),
    .item    (s1_item),
    .st_next (st_next),
    .verdict (verdict_next)
  );

  // A non-last byte never needs the result slot, so it always moves on.
  assign slot_free  = !verdict_valid || !verdict_stall;
  assign advance    = s1_valid && (!s1_item.last_byte || slot_free);
  assign byte_stall = s1_valid && !advance;
  assign accept     = byte_valid && !byte_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_item <= byte_item;
    end
  end

  // Decoder state; cleared after each last byte inside the step logic.
  always_ff @(posedge clk) begin
    if (rst) begin
      st <= '0;
    end else if (advance) begin
      st <= st_next;
    end
  end

  // Result register: holds a verdict until the far side takes it.
  always_ff @(posedge clk) begin
    if (rst) begin
      verdict_valid <= 1'b0;
    end else if (advance && s1_item.last_byte) begin
      verdict_valid <= 1'b1;
    end else if (!verdict_stall) begin
      verdict_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s1_item.last_byte) begin
      verdict_item <= verdict_next;
    end
  end

`ifndef SYNTHESIS
  a_last_gives_verdict: assert property (@(posedge clk) disable iff (rst)
    (advance && s1_item.last_byte) |=> verdict_valid)
    else $error("last item did not produce a verdict");

  a_state_cleared: assert property (@(posedge clk) disable iff (rst)
    (advance && s1_item.last_byte) |=> (st == '0))
    else $error("decoder state not cleared after last item");

  a_valid_implies_clean: assert property (@(posedge clk) disable iff (rst)
    verdict_valid |-> (!verdict_item.utf8_valid || verdict_item.control_free))
    else $error("strict pass with control error");

  a_pending_bound: assert property (@(posedge clk) disable iff (rst)
    st.bytes_pending <= st.sequence_length)
    else $error("pending count exceeds sequence length");

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    byte_stall |-> (s1_valid && s1_item.last_byte && verdict_valid && verdict_stall))
    else $error("input stalled without a blocked verdict");
`endif

endmodule
